// File: design/hbc_pkg.sv
// Shared types, constants and codes for the hashed block cache.
package hbc_pkg;

  localparam int NUM_SLOTS    = 32;
  localparam int NUM_BUCKETS  = 13;
  localparam int SLOT_W       = 5;
  localparam int BUCKET_W     = 4;
  localparam int HASH_W       = 28;
  localparam int HASH_NIBBLES = HASH_W / 4;
  localparam int HCNT_W       = 3;
  localparam logic [31:0] STAMP_NONE = 32'hffffffff;
  localparam logic [7:0]  REF_MAX    = 8'hff;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  device;
    logic [23:0] block_number;
    logic [4:0]  slot_index;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [4:0] slot;
    logic [1:0] status;
    logic       needs_fill;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_HASH, S_SCAN, S_PICK, S_APPLY, S_OPER, S_FINISH
  } state_t;

  typedef struct packed {
    logic ready;
    logic load;
    logic hash_step;
    logic scan_step;
    logic pick;
    logic apply_get;
    logic apply_op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_get;
    logic hash_last;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

// File: design/hashed_block_cache_lru.sv
// Top level of the hashed block cache with least-recently-released replacement.
// A get runs the bucket hash, one nibble per cycle,
// then the tag and victim scan, one slot per cycle, plus control steps.
// Release, pin and unpin skip the hash and scan. One word is in work at a time.
// Synchronous reset empties the output and sets every slot to tag zero in bucket zero.
module hashed_block_cache_lru (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  hbc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output hbc_pkg::rsp_t rsp
);

  hbc_pkg::cmd_t  cmd;
  hbc_pkg::stat_t stat;

  hbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  hbc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign req_stall = !cmd.ready;

endmodule

// File: design/hbc_ctrl.sv
// Controller state machine that sequences each word through the datapath.
module hbc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  hbc_pkg::stat_t stat,
  output hbc_pkg::cmd_t  cmd
);

  hbc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hbc_pkg::S_IDLE: begin
        if (req_valid) state_next = hbc_pkg::S_START;
      end
      hbc_pkg::S_START: begin
        state_next = stat.is_get ? hbc_pkg::S_HASH : hbc_pkg::S_OPER;
      end
      hbc_pkg::S_HASH: begin
        if (stat.hash_last) state_next = hbc_pkg::S_SCAN;
      end
      hbc_pkg::S_SCAN: begin
        if (stat.scan_last) state_next = hbc_pkg::S_PICK;
      end
      hbc_pkg::S_PICK:  state_next = hbc_pkg::S_APPLY;
      hbc_pkg::S_APPLY: state_next = hbc_pkg::S_FINISH;
      hbc_pkg::S_OPER:  state_next = hbc_pkg::S_FINISH;
      hbc_pkg::S_FINISH: begin
        if (stat.out_free) state_next = hbc_pkg::S_IDLE;
      end
      default: state_next = hbc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      hbc_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        cmd.load  = req_valid;
      end
      hbc_pkg::S_HASH:   cmd.hash_step = 1'b1;
      hbc_pkg::S_SCAN:   cmd.scan_step = 1'b1;
      hbc_pkg::S_PICK:   cmd.pick      = 1'b1;
      hbc_pkg::S_APPLY:  cmd.apply_get = 1'b1;
      hbc_pkg::S_OPER:   cmd.apply_op  = 1'b1;
      hbc_pkg::S_FINISH: cmd.emit      = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/hbc_datapath.sv
// Datapath with the slot tables, bucket hash, scan trackers and output register.
module hbc_datapath (
  input  logic           clk,
  input  logic           rst,
  input  hbc_pkg::req_t  req,
  input  hbc_pkg::cmd_t  cmd,
  output hbc_pkg::stat_t stat,
  input  logic           rsp_stall,
  output logic           rsp_valid,
  output hbc_pkg::rsp_t  rsp
);

  localparam int SW = hbc_pkg::SLOT_W;
  localparam int BW = hbc_pkg::BUCKET_W;
  localparam int NS = hbc_pkg::NUM_SLOTS;
  localparam int NB = hbc_pkg::NUM_BUCKETS;

  logic [1:0]  op_r;
  logic [7:0]  dev_r;
  logic [23:0] blk_r;
  logic [SW-1:0] idx_r;
  logic [31:0] now_r;
  logic [hbc_pkg::HASH_W-1:0] hsh;
  logic [hbc_pkg::HCNT_W-1:0] hcnt;
  logic [BW-1:0] rem_r;
  logic [SW-1:0] cnt;

  logic [7:0]    tag_dev [NS];
  logic [23:0]   tag_blk [NS];
  logic [7:0]    ref_cnt [NS];
  logic [31:0]   stamp   [NS];
  logic          cvalid  [NS];
  logic [BW-1:0] bkt     [NS];
  logic [31:0]   iord    [NS];
  logic [31:0]   icnt;

  logic          hit_v;
  logic [SW-1:0] hit_idx;
  logic [31:0]   hit_ord;
  logic          bv   [NB];
  logic [SW-1:0] bidx [NB];
  logic [31:0]   bst  [NB];
  logic [31:0]   bord [NB];
  logic          vic_v;
  logic [SW-1:0] vic_idx;
  hbc_pkg::rsp_t res, res_next;

  logic [7:0]    hv;
  logic [SW-1:0] raddr, tgt;
  logic [BW-1:0] rb;
  logic [31:0]   rs, ro;
  logic [7:0]    rr;
  logic          rv, hit_m, elig, better, pv;
  logic [SW-1:0] pidx;

  always_comb begin
    hv = {rem_r, hsh[hbc_pkg::HASH_W-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (hv >= 8'(NB << k)) hv = hv - 8'(NB << k);
    end
  end

  assign tgt = hit_v ? hit_idx : vic_idx;

  always_comb begin
    if (cmd.scan_step) begin
      raddr = cnt;
    end else if (cmd.apply_op) begin
      raddr = idx_r;
    end else begin
      raddr = tgt;
    end
  end

  assign rb = bkt[raddr];
  assign rs = stamp[raddr];
  assign ro = iord[raddr];
  assign rr = ref_cnt[raddr];
  assign rv = cvalid[raddr];
  assign hit_m = (rb == rem_r) && (tag_dev[raddr] == dev_r) && (tag_blk[raddr] == blk_r);
  assign elig = (rr == 8'd0) && (rs != hbc_pkg::STAMP_NONE);
  assign better = !bv[rb] || (rs < bst[rb]) || ((rs == bst[rb]) && (ro > bord[rb]));

  always_comb begin
    pv = 1'b0;
    pidx = '0;
    for (int b = NB - 1; b >= 0; b--) begin
      if (bv[b] && (BW'(b) != rem_r)) begin
        pv = 1'b1;
        pidx = bidx[b];
      end
    end
  end

  always_comb begin
    res_next = '0;
    if (cmd.apply_op) begin
      res_next.slot = idx_r;
      if (op_r == hbc_pkg::OP_PIN) begin
        res_next.status = (rr == hbc_pkg::REF_MAX) ? hbc_pkg::ST_FAULT : hbc_pkg::ST_DONE;
      end else begin
        res_next.status = (rr == 8'd0) ? hbc_pkg::ST_FAULT : hbc_pkg::ST_DONE;
      end
    end else if (hit_v) begin
      res_next.slot = hit_idx;
      if (rr == hbc_pkg::REF_MAX) begin
        res_next.status = hbc_pkg::ST_FAULT;
      end else begin
        res_next.status = hbc_pkg::ST_DONE;
        res_next.needs_fill = !rv;
      end
    end else if (vic_v) begin
      res_next.slot = vic_idx;
      res_next.status = hbc_pkg::ST_MISS;
      res_next.needs_fill = 1'b1;
    end else begin
      res_next.status = hbc_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= req.operation;
      dev_r <= req.device;
      blk_r <= req.block_number;
      idx_r <= req.slot_index;
      now_r <= req.now;
      hsh   <= hbc_pkg::HASH_W'(25'(req.device) + 25'(req.block_number));
      rem_r <= '0;
      hcnt  <= '0;
      cnt   <= '0;
      hit_v <= 1'b0;
      for (int b = 0; b < NB; b++) bv[b] <= 1'b0;
    end
    if (cmd.hash_step) begin
      rem_r <= hv[BW-1:0];
      hsh   <= hsh << 4;
      hcnt  <= hcnt + 1'b1;
    end
    if (cmd.scan_step) begin
      cnt <= cnt + 1'b1;
      if (hit_m && (!hit_v || (ro > hit_ord))) begin
        hit_v   <= 1'b1;
        hit_idx <= cnt;
        hit_ord <= ro;
      end
      if (elig && better) begin
        bv[rb]   <= 1'b1;
        bidx[rb] <= cnt;
        bst[rb]  <= rs;
        bord[rb] <= ro;
      end
    end
    if (cmd.pick) begin
      vic_v   <= pv;
      vic_idx <= pidx;
    end
    if (cmd.apply_get || cmd.apply_op) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        tag_dev[i] <= '0;
        tag_blk[i] <= '0;
        ref_cnt[i] <= '0;
        stamp[i]   <= '0;
        cvalid[i]  <= 1'b0;
        bkt[i]     <= '0;
        iord[i]    <= 32'(i);
      end
      icnt <= 32'(NS);
    end else if (cmd.apply_get) begin
      if (hit_v) begin
        if (rr != hbc_pkg::REF_MAX) begin
          ref_cnt[tgt] <= rr + 8'd1;
          cvalid[tgt]  <= 1'b1;
        end
      end else if (vic_v) begin
        bkt[tgt]     <= rem_r;
        iord[tgt]    <= icnt;
        icnt         <= icnt + 32'd1;
        tag_dev[tgt] <= dev_r;
        tag_blk[tgt] <= blk_r;
        ref_cnt[tgt] <= 8'd1;
        cvalid[tgt]  <= 1'b1;
      end
    end else if (cmd.apply_op) begin
      if (op_r == hbc_pkg::OP_PIN) begin
        if (rr != hbc_pkg::REF_MAX) ref_cnt[idx_r] <= rr + 8'd1;
      end else if (rr != 8'd0) begin
        ref_cnt[idx_r] <= rr - 8'd1;
        if ((op_r == hbc_pkg::OP_RELEASE) && (rr == 8'd1)) stamp[idx_r] <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) rsp <= res;
  end

  assign stat.is_get    = (op_r == hbc_pkg::OP_GET);
  assign stat.hash_last = (hcnt == hbc_pkg::HCNT_W'(hbc_pkg::HASH_NIBBLES - 1));
  assign stat.scan_last = (cnt == SW'(NS - 1));
  assign stat.out_free  = !rsp_valid || !rsp_stall;

endmodule

// File: design/hbc_checker.sv
// Port-level checker for the hashed block cache and its bind statement.
module hbc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input hbc_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input hbc_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second word taken while one is in work");

  a_miss_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == hbc_pkg::ST_MISS) |-> rsp.needs_fill)
    else $error("allocated slot not flagged for fill");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == hbc_pkg::ST_FULL) |-> (rsp.slot == '0) && !rsp.needs_fill)
    else $error("no-free-slot response carries data");

endmodule

bind hashed_block_cache_lru hbc_checker u_chk (.*);

// File: tb/tb_checker.sv
// Checker for the hashed block cache: predicts each response word and compares it.
module tb_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  hbc_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  hbc_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  tag_dev   [hbc_pkg::NUM_SLOTS];
  logic [23:0] tag_blk   [hbc_pkg::NUM_SLOTS];
  logic [7:0]  refs      [hbc_pkg::NUM_SLOTS];
  logic [31:0] stamp     [hbc_pkg::NUM_SLOTS];
  logic        filled    [hbc_pkg::NUM_SLOTS];
  logic [3:0]  bucket    [hbc_pkg::NUM_SLOTS];
  logic [31:0] age       [hbc_pkg::NUM_SLOTS];
  logic [31:0] age_next;
  hbc_pkg::rsp_t expected_rsp [$];

  task automatic report(input string what, input hbc_pkg::rsp_t got,
                        input hbc_pkg::rsp_t want);
    $display("mismatch %s: got slot %0d status %0d fill %0d, want slot %0d status %0d fill %0d",
             what, got.slot, got.status, got.needs_fill, want.slot, want.status,
             want.needs_fill);
    fail_count++;
  endtask

  function automatic hbc_pkg::rsp_t cache_step(input hbc_pkg::req_t r);
    hbc_pkg::rsp_t o;
    int            hit;
    int            victim;
    logic [3:0]    hb;
    o = '0;
    if (r.operation == hbc_pkg::OP_GET) begin
      hb = 4'((32'(r.device) + 32'(r.block_number)) % hbc_pkg::NUM_BUCKETS);
      hit = -1;
      for (int i = 0; i < hbc_pkg::NUM_SLOTS; i++)
        if (bucket[i] == hb && tag_dev[i] == r.device && tag_blk[i] == r.block_number)
          if (hit < 0 || age[i] > age[hit]) hit = i;
      if (hit >= 0) begin
        o.slot = 5'(hit);
        if (refs[hit] == hbc_pkg::REF_MAX) begin
          o.status = hbc_pkg::ST_FAULT;
        end else begin
          refs[hit]++;
          o.status = hbc_pkg::ST_DONE;
          o.needs_fill = !filled[hit];
          filled[hit] = 1'b1;
        end
        return o;
      end
      victim = -1;
      for (int b = 0; b < hbc_pkg::NUM_BUCKETS && victim < 0; b++) begin
        if (b == hb) continue;
        for (int i = 0; i < hbc_pkg::NUM_SLOTS; i++) begin
          if (bucket[i] != b || refs[i] != 0 || stamp[i] == hbc_pkg::STAMP_NONE) continue;
          if (victim < 0 || stamp[i] < stamp[victim] ||
              (stamp[i] == stamp[victim] && age[i] > age[victim]))
            victim = i;
        end
      end
      if (victim < 0) begin
        o.status = hbc_pkg::ST_FULL;
        return o;
      end
      bucket[victim] = hb;
      age[victim] = age_next;
      age_next++;
      tag_dev[victim] = r.device;
      tag_blk[victim] = r.block_number;
      refs[victim] = 8'd1;
      filled[victim] = 1'b1;
      o.slot = 5'(victim);
      o.status = hbc_pkg::ST_MISS;
      o.needs_fill = 1'b1;
      return o;
    end
    o.slot = r.slot_index;
    if (r.operation == hbc_pkg::OP_PIN) begin
      if (refs[r.slot_index] == hbc_pkg::REF_MAX) begin
        o.status = hbc_pkg::ST_FAULT;
      end else begin
        refs[r.slot_index]++;
      end
      return o;
    end
    if (refs[r.slot_index] == 0) begin
      o.status = hbc_pkg::ST_FAULT;
      return o;
    end
    refs[r.slot_index]--;
    if (r.operation == hbc_pkg::OP_RELEASE && refs[r.slot_index] == 0)
      stamp[r.slot_index] = r.now;
    return o;
  endfunction

  always @(posedge clk) begin
    hbc_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < hbc_pkg::NUM_SLOTS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i] = '0;
        stamp[i] = '0;
        filled[i] = 1'b0;
        bucket[i] = '0;
        age[i] = 32'(i);
      end
      age_next = 32'(hbc_pkg::NUM_SLOTS);
      expected_rsp.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected word", rsp, '0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.slot !== want.slot) report("slot", rsp, want);
          else if (rsp.status !== want.status) report("status", rsp, want);
          else if (rsp.needs_fill !== want.needs_fill) report("needs_fill", rsp, want);
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(cache_step(req));
    end
    pending = expected_rsp.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the hashed block cache testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  hbc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  hbc_pkg::rsp_t rsp;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  logic [7:0]  hot_dev [8];
  logic [23:0] hot_blk [8];

  hashed_block_cache_lru u_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  tb_checker u_checker (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_word(input hbc_pkg::req_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] dev, input logic [23:0] blk,
                         input logic [4:0] idx, input logic [31:0] tick);
    hbc_pkg::req_t w;
    w.operation = op;
    w.device = dev;
    w.block_number = blk;
    w.slot_index = idx;
    w.now = tick;
    send_word(w);
  endtask

  task automatic send_random();
    int          pick;
    logic [31:0] tick;
    pick = $urandom_range(99);
    tick = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(63));
    if ($urandom_range(19) == 0) tick = hbc_pkg::STAMP_NONE;
    if (pick < 35) begin
      pick = $urandom_range(7);
      send_op(hbc_pkg::OP_GET, hot_dev[pick], hot_blk[pick], 5'($urandom), $urandom);
    end else if (pick < 45) begin
      send_op(hbc_pkg::OP_GET, 8'($urandom), 24'($urandom), 5'($urandom), $urandom);
    end else if (pick < 75) begin
      send_op(hbc_pkg::OP_RELEASE, 8'($urandom), 24'($urandom), 5'($urandom), tick);
    end else if (pick < 87) begin
      send_op(hbc_pkg::OP_PIN, 8'($urandom), 24'($urandom), 5'($urandom), tick);
    end else begin
      send_op(hbc_pkg::OP_UNPIN, 8'($urandom), 24'($urandom), 5'($urandom), tick);
    end
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      hot_dev[i] = 8'($urandom);
      hot_blk[i] = 24'($urandom);
    end
    hot_dev[0] = 8'd0;
    hot_blk[0] = 24'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_op(hbc_pkg::OP_GET, 8'd0, 24'd0, 5'd0, 32'd0);
    send_op(hbc_pkg::OP_GET, 8'd0, 24'd0, 5'd0, 32'd0);
    send_op(hbc_pkg::OP_GET, 8'hff, 24'hffffff, 5'd31, 32'hffffffff);
    send_op(hbc_pkg::OP_RELEASE, 8'd0, 24'd0, 5'd31, 32'd5);
    send_op(hbc_pkg::OP_RELEASE, 8'd0, 24'd0, 5'd31, 32'd5);
    send_op(hbc_pkg::OP_UNPIN, 8'd0, 24'd0, 5'd31, 32'd0);
    send_op(hbc_pkg::OP_PIN, 8'hff, 24'hffffff, 5'd3, 32'hffffffff);
    send_op(hbc_pkg::OP_UNPIN, 8'd0, 24'd0, 5'd3, 32'd0);
    send_op(hbc_pkg::OP_RELEASE, 8'd0, 24'd0, 5'd31, 32'd0);
    send_op(hbc_pkg::OP_GET, 8'd1, 24'd2, 5'd0, 32'd0);
    send_op(hbc_pkg::OP_GET, 8'd12, 24'd1, 5'd0, 32'd0);
    send_op(hbc_pkg::OP_GET, 8'h80, 24'h800000, 5'd0, 32'd0);
    for (int i = 0; i < 256; i++) send_op(hbc_pkg::OP_PIN, 8'd0, 24'd0, 5'd7, 32'd0);
    send_op(hbc_pkg::OP_GET, 8'd0, 24'd0, 5'd0, 32'd0);
    for (int i = 0; i < 256; i++)
      send_op(hbc_pkg::OP_RELEASE, 8'd0, 24'd0, 5'd7, 32'hffffffff);
    send_op(hbc_pkg::OP_GET, 8'd3, 24'd3, 5'd0, 32'd0);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 83 : 34) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 83 : 34) : 0;
      for (int n = 0; n < 125; n++) send_random();
    end

    req_valid <= 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("** hashed_block_cache_lru: PASSED **");
    end else begin
      $display("** hashed_block_cache_lru: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** hashed_block_cache_lru: FAILED **");
    $finish;
  end

endmodule
